@@ design/ihd_pkg.sv @@
`timescale 1ns / 1ps

package ihd_pkg;

	localparam int unsigned CODE_W = 8;
	localparam int unsigned MASK_W = 32;
	localparam int unsigned POS_W  = 6;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [MASK_W-1:0] mask_t;

	typedef struct packed {
		logic  first;
		logic  is_branch;
		logic  is_load;
		code_t dest_code;
		code_t src_a_code;
		code_t src_b_code;
	} in_item_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		mask_t            raw_mask;
		mask_t            war_mask;
		mask_t            waw_mask;
		logic             load_use;
		logic             overflow;
	} out_item_t;

	// one stored window entry
	typedef struct packed {
		logic  is_branch;
		logic  is_load;
		code_t dest_code;
		code_t src_a_code;
		code_t src_b_code;
	} entry_t;

	typedef struct packed {
		logic capture;
		logic rd_issue;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic last_issue;
		logic out_free;
	} ctrl_status_t;

	// absent operands never match
	function automatic logic same_reg(input code_t x, input code_t y);
		return (x != '0) && (x == y);
	endfunction

endpackage

@@ design/ihd_ifs.sv @@
`timescale 1ns / 1ps

interface ihd_in_if;
	logic             valid;
	logic             ready;
	ihd_pkg::in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ihd_out_if;
	logic              valid;
	logic              ready;
	ihd_pkg::out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ design/instruction_hazard_detector.sv @@
`timescale 1ns / 1ps

// Instruction hazard detector.
// in_ch takes one decoded instruction per item (first, branch and load marks,
// destination and two source codes, code 0 meaning absent). out_ch returns one
// item per instruction: its window position, RAW/WAR/WAW masks over earlier
// non-branch entries, a load-use flag and an overflow flag.
// Each item walks the stored entries through one shared set of comparators, one
// entry per cycle from the window RAM's read port: the item is captured, each
// stored entry is read and compared, a drain step takes the last read, and a
// final step loads the result (an empty or full window skips straight to it).
// One item is worked on at a time; in_ch is ready again as soon as the result
// is loaded into the output register, so the next item can be taken while that
// result waits.
// A stalled out_ch holds the result and the block waits in its final step
// before storing the next instruction.
// Reset empties the window (entry count zero) and drops any pending result.
// A first mark restarts the window at position one; a full window reports
// overflow with position 0 and stores nothing.
module instruction_hazard_detector #(
	parameter int unsigned WINDOW = 32
) (
	input logic             clk,
	input logic             arst_n,
	ihd_in_if.sink          in_ch,
	ihd_out_if.source       out_ch
);

	ihd_pkg::ctrl_cmd_t    cmd;
	ihd_pkg::ctrl_status_t status;

	ihd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	ihd_datapath #(
		.WINDOW (WINDOW)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.in_payload  (in_ch.payload),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.out_payload (out_ch.payload)
	);

endmodule

@@ design/ihd_ram.sv @@
`timescale 1ns / 1ps

module ihd_ram #(
	parameter int unsigned WIDTH = 26,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/ihd_ctrl.sv @@
`timescale 1ns / 1ps

module ihd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ihd_pkg::ctrl_status_t status,
	output ihd_pkg::ctrl_cmd_t    cmd
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_FIN   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd.capture  = 1'b0;
		cmd.rd_issue = 1'b0;
		cmd.finish   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_SCAN;
				end
			end
			S_SCAN: begin
				// nothing to walk when empty; full window skips the walk too
				if (status.empty || status.full) begin
					state_d = S_FIN;
				end else begin
					cmd.rd_issue = 1'b1;
					if (status.last_issue) begin
						state_d = S_DRAIN;
					end
				end
			end
			S_DRAIN: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ design/ihd_datapath.sv @@
`timescale 1ns / 1ps

module ihd_datapath #(
	parameter int unsigned WINDOW = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ihd_pkg::ctrl_cmd_t    cmd,
	output ihd_pkg::ctrl_status_t status,
	input  ihd_pkg::in_item_t     in_payload,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ihd_pkg::out_item_t    out_payload
);

	localparam int unsigned CW = $clog2(WINDOW + 1);
	localparam int unsigned IW = $clog2(WINDOW);
	localparam int unsigned EW = $bits(ihd_pkg::entry_t);

	ihd_pkg::in_item_t item_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     k_q;
	logic [CW-1:0]     k_s1;
	logic              rd_s1;
	ihd_pkg::mask_t    raw_q;
	ihd_pkg::mask_t    war_q;
	ihd_pkg::mask_t    waw_q;
	logic              lu_q;
	logic              out_valid_q;
	ihd_pkg::out_item_t out_q;

	ihd_pkg::entry_t   rd_entry;
	logic [EW-1:0]     rd_bits;
	ihd_pkg::entry_t   wr_entry;
	logic [CW-1:0]     last_idx;
	logic [CW:0]       pos_sum;
	logic              full;
	logic              hit_r;
	logic              hit_w;
	logic              hit_o;
	ihd_pkg::mask_t    bit_sel;

	assign full     = (count_q >= CW'(WINDOW));
	assign last_idx = count_q - CW'(1);
	assign pos_sum  = {1'b0, count_q} + (CW+1)'(1);

	assign status.empty      = (count_q == '0);
	assign status.full       = full;
	assign status.last_issue = (k_q == last_idx);
	assign status.out_free   = !out_valid_q || out_ready;

	assign wr_entry.is_branch  = item_q.is_branch;
	assign wr_entry.is_load    = item_q.is_load;
	assign wr_entry.dest_code  = item_q.dest_code;
	assign wr_entry.src_a_code = item_q.src_a_code;
	assign wr_entry.src_b_code = item_q.src_b_code;

	ihd_ram #(
		.WIDTH (EW),
		.DEPTH (WINDOW)
	) u_ram (
		.clk   (clk),
		.we    (cmd.finish && !full),
		.waddr (count_q[IW-1:0]),
		.wdata (wr_entry),
		.raddr (k_q[IW-1:0]),
		.rdata (rd_bits)
	);

	assign rd_entry = rd_bits;

	// compare the entry read last cycle against the held item
	assign hit_r = !rd_entry.is_branch &&
		(ihd_pkg::same_reg(rd_entry.dest_code, item_q.src_a_code) ||
		 ihd_pkg::same_reg(rd_entry.dest_code, item_q.src_b_code));
	assign hit_w = !rd_entry.is_branch &&
		(ihd_pkg::same_reg(rd_entry.src_a_code, item_q.dest_code) ||
		 ihd_pkg::same_reg(rd_entry.src_b_code, item_q.dest_code));
	assign hit_o = !rd_entry.is_branch &&
		ihd_pkg::same_reg(rd_entry.dest_code, item_q.dest_code);

	// entries at index 32 and up get no mask bit
	assign bit_sel = (32'(k_s1) < ihd_pkg::MASK_W) ? (ihd_pkg::mask_t'(1) << k_s1) : '0;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_payload;
			raw_q  <= '0;
			war_q  <= '0;
			waw_q  <= '0;
			lu_q   <= 1'b0;
		end else if (rd_s1) begin
			if (hit_r) raw_q <= raw_q | bit_sel;
			if (hit_w) war_q <= war_q | bit_sel;
			if (hit_o) waw_q <= waw_q | bit_sel;
			if (hit_r && rd_entry.is_load && (k_s1 == last_idx)) lu_q <= 1'b1;
		end
		k_s1 <= k_q;
		if (cmd.finish) begin
			if (full) begin
				out_q.position <= '0;
				out_q.raw_mask <= '0;
				out_q.war_mask <= '0;
				out_q.waw_mask <= '0;
				out_q.load_use <= 1'b0;
				out_q.overflow <= 1'b1;
			end else begin
				out_q.position <= ihd_pkg::POS_W'(pos_sum);
				out_q.raw_mask <= raw_q;
				out_q.war_mask <= war_q;
				out_q.waw_mask <= waw_q;
				out_q.load_use <= lu_q;
				out_q.overflow <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			k_q         <= '0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd_issue;
			if (cmd.capture) begin
				k_q <= '0;
				if (in_payload.first) begin
					count_q <= '0;
				end
			end else if (cmd.rd_issue) begin
				k_q <= k_q + CW'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				if (!full) begin
					count_q <= count_q + CW'(1);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_payload = out_q;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import ihd_pkg::*;

	localparam int unsigned WINDOW     = 32;
	localparam int unsigned STALL_LIMIT = 2000;

	// Tracks the hazard window and the hazard reports still owed by the block.
	class hazard_scoreboard #(int unsigned WIN = 32);
		entry_t      slots[WIN];
		int unsigned fill;
		out_item_t   pending_reports[$];
		int unsigned mismatches;

		function new();
			fill = 0;
			mismatches = 0;
		endfunction

		static function bit reg_hit(code_t stored, code_t probe);
			return stored != 8'd0 && stored == probe;
		endfunction

		function out_item_t compute_hazards(in_item_t ins);
			out_item_t rep;
			entry_t    e;
			bit        rd, wr, ow;
			rep = '0;
			if (ins.first)
				fill = 0;
			if (fill >= WIN) begin
				rep.overflow = 1'b1;
				return rep;
			end
			for (int unsigned k = 0; k < fill; k++) begin
				e = slots[k];
				if (!e.is_branch) begin
					rd = reg_hit(e.dest_code, ins.src_a_code) || reg_hit(e.dest_code, ins.src_b_code);
					wr = reg_hit(e.src_a_code, ins.dest_code) || reg_hit(e.src_b_code, ins.dest_code);
					ow = reg_hit(e.dest_code, ins.dest_code);
					if (k < MASK_W) begin
						rep.raw_mask[k] = rd;
						rep.war_mask[k] = wr;
						rep.waw_mask[k] = ow;
					end
					if (rd && e.is_load && k + 1 == fill)
						rep.load_use = 1'b1;
				end
			end
			slots[fill] = '{ins.is_branch, ins.is_load, ins.dest_code, ins.src_a_code,
				ins.src_b_code};
			fill++;
			rep.position = fill[POS_W-1:0];
			return rep;
		endfunction

		function void note_instr(in_item_t ins);
			pending_reports = {pending_reports, compute_hazards(ins)};
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_report(out_item_t got);
			out_item_t want;
			if (pending_reports.size() == 0) begin
				$error("hazard report with no instruction waiting: %p", got);
				mismatches++;
				return;
			end
			want = pending_reports.pop_front();
			compare_field("position", 32'(want.position), 32'(got.position));
			compare_field("raw_mask", want.raw_mask, got.raw_mask);
			compare_field("war_mask", want.war_mask, got.war_mask);
			compare_field("waw_mask", want.waw_mask, got.waw_mask);
			compare_field("load_use", 32'(want.load_use), 32'(got.load_use));
			compare_field("overflow", 32'(want.overflow), 32'(got.overflow));
		endfunction

		function int unsigned outstanding();
			return pending_reports.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ihd_in_if  in_ch ();
	ihd_out_if out_ch ();

	instruction_hazard_detector #(.WINDOW(WINDOW)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	hazard_scoreboard #(WINDOW) sb;
	bit          idle_on;
	int unsigned stall_left;
	int unsigned quiet_cycles;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		out_ch.ready = 1'b0;
		idle_on = 1'b1;
		stall_left = 0;
		quiet_cycles = 0;
		sb = new();
	end

	always #6 clk = ~clk;

	// Result side: check every accepted result, then stall in random bursts while idle_on is set.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready)
				sb.check_report(out_ch.payload);
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 3);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Hold the item until accepted; while idle_on is set, idle first in a short burst now and then.
	task automatic send_instr(in_item_t ins);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.payload <= ins;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_instr(ins);
	endtask

	// Mostly a few low codes so hazards are frequent; absent and wide codes too.
	function automatic code_t pick_code();
		int unsigned sel;
		sel = $urandom_range(0, 19);
		if (sel < 3)
			return 8'd0;
		else if (sel < 15)
			return code_t'($urandom_range(1, 6));
		else
			return code_t'($urandom_range(0, 255));
	endfunction

	function automatic in_item_t random_instr();
		in_item_t ins;
		ins.first = ($urandom_range(0, 39) == 0);
		ins.is_branch = ($urandom_range(0, 5) == 0);
		ins.is_load = ($urandom_range(0, 3) == 0);
		ins.dest_code = pick_code();
		ins.src_a_code = pick_code();
		ins.src_b_code = pick_code();
		return ins;
	endfunction

	task automatic send_random(int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			send_instr(random_instr());
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fields: first, branch, load, dest, src_a, src_b
		send_instr(in_item_t'{1'b0, 1'b0, 1'b0, 8'd1, 8'd2, 8'd3});
		send_instr(in_item_t'{1'b0, 1'b0, 1'b1, 8'd4, 8'd1, 8'd0});
		send_instr(in_item_t'{1'b0, 1'b0, 1'b0, 8'd5, 8'd4, 8'd4});
		send_instr(in_item_t'{1'b0, 1'b1, 1'b0, 8'd0, 8'd5, 8'd1});
		send_instr(in_item_t'{1'b0, 1'b0, 1'b0, 8'd5, 8'd0, 8'd0});
		send_instr(in_item_t'{1'b0, 1'b0, 1'b1, 8'd255, 8'd255, 8'd255});
		send_instr(in_item_t'{1'b0, 1'b0, 1'b0, 8'd255, 8'd255, 8'd0});
		// branch marked as load: never a producer, so no load-use below
		send_instr(in_item_t'{1'b0, 1'b1, 1'b1, 8'd7, 8'd0, 8'd0});
		send_instr(in_item_t'{1'b0, 1'b0, 1'b0, 8'd8, 8'd7, 8'd7});
		send_instr(in_item_t'{1'b0, 1'b0, 1'b1, 8'd0, 8'd0, 8'd0});
		send_instr(in_item_t'{1'b0, 1'b0, 1'b0, 8'd1, 8'd5, 8'd255});
		send_instr(in_item_t'{1'b1, 1'b0, 1'b0, 8'd170, 8'd85, 8'd170});
		send_instr(in_item_t'{1'b0, 1'b0, 1'b1, 8'd85, 8'd170, 8'd85});
		send_instr(in_item_t'{1'b0, 1'b0, 1'b0, 8'd1, 8'd85, 8'd0});
		send_instr(in_item_t'{1'b0, 1'b0, 1'b0, 8'd2, 8'd0, 8'd85});

		send_random(200);

		// hold the sender until the block has drained
		in_ch.valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);

		idle_on = 1'b0;
		send_random(100);
		idle_on = 1'b1;
		send_random(150);
		idle_on = 1'b0;
		send_random(50);
		in_ch.valid <= 1'b0;

		while (sb.outstanding() != 0) @(posedge clk);
		repeat (WINDOW + 8) @(posedge clk);
		if (sb.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
